[sv/csmtc_pkg.sv]
// Shared types, constants and fixed-point helpers for the cascade thrust controller.
// Used by every module of the block; depends on nothing.
package csmtc_pkg;

  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int GAIN_W     = 31;
  localparam int THRUST_W   = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SURGE_ROOT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURGE_LINEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAY_ROOT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAY_LINEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ROOT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LINEAR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_PROP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_DERIV = 3'd7;

  localparam int RST_ROOT_GAIN   = 6554;
  localparam int RST_LINEAR_GAIN = 66;
  localparam int RST_PROP_GAIN   = 262;
  localparam int RST_DERIV_GAIN  = 393;

  localparam int LAMBDA_SURGE     = 66;
  localparam int LAMBDA_SWAY      = 66;
  localparam int LAMBDA_TURN      = 66;
  localparam int HEADING_INT_GAIN = 0;
  localparam int MAX_THRUST       = 32768;

  localparam int Q_DEADBAND   = 328;
  localparam int Q_TENTH      = 6554;
  localparam int Q_ONE_HALF_3 = 98304;
  localparam int Q_RATE_LIMIT = 16384;
  localparam int Q_STEP       = 1311;
  localparam int Q_PI         = 205887;
  localparam int Q_TWO_PI     = 411775;
  localparam int Q_AUX_UV     = -163840;
  localparam int Q_AUX_SR     = -6554;
  localparam int Q_HALF_COS   = 23170;
  localparam int Q_INV_4D     = 210051;

  typedef logic signed [32:0] mop_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [39:0] alloc_t;

  typedef struct packed {
    mop_t a;
    mop_t b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        start;
    logic [55:0] num;
    logic [39:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input prod_t x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // round to nearest, ties up, then drop 16 fraction bits
  function automatic prod_t rnd16(input prod_t p);
    return (p + 66'sd32768) >>> 16;
  endfunction

  function automatic prod_t rnd17(input prod_t p);
    return (p + 66'sd65536) >>> 17;
  endfunction

  function automatic logic signed [31:0] qm(input prod_t p);
    return sat32(rnd16(p));
  endfunction

endpackage

[sv/csmtc_mul.sv]
// Shared 33x33 signed multiplier with a registered product.
// Depends on csmtc_pkg.
module csmtc_mul (
  input  logic                clk,
  input  csmtc_pkg::mul_req_t req,
  output csmtc_pkg::prod_t    p
);

  always_ff @(posedge clk) begin
    p <= 66'(req.a) * 66'(req.b);
  end

endmodule

[sv/csmtc_sqrt.sv]
// Iterative floor square root of a 64-bit value, one result bit a cycle.
// Depends on csmtc_pkg.
module csmtc_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  csmtc_pkg::sqrt_req_t req,
  output logic                 done,
  output logic [31:0]          root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= req.radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/csmtc_div.sv]
// Restoring divider, 17 quotient bits, one bit a cycle; quotient must stay below 2^17.
// Depends on csmtc_pkg.
module csmtc_div (
  input  logic                clk,
  input  logic                rst,
  input  csmtc_pkg::div_req_t req,
  output logic                done,
  output logic [16:0]         quo
);

  logic [55:0] rem;
  logic [56:0] dsh;
  logic [4:0]  cnt;
  logic        busy;
  logic [57:0] diff;

  assign diff = {2'b00, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= req.num;
        dsh  <= {1'b0, req.den, 16'b0};
        quo  <= '0;
      end else if (busy) begin
        if (!diff[57]) begin
          rem <= diff[55:0];
        end
        quo <= {quo[15:0], ~diff[57]};
        dsh <= dsh >> 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/cascade_sliding_mode_thrust_controller.sv]
// Top level: sequencer and state of the cascade sliding-mode thrust controller.
// Depends on csmtc_pkg, csmtc_mul, csmtc_sqrt, csmtc_div.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | tvalid/tready      | one measurement word per control tick
//  m_*     | out       | tvalid/tready      | four thruster commands
//  cfg_*   | in        | cfg_we             | gain register writes
//
// Each word runs through four square roots and up to eight divisions in the shared
// units, and through the registered multiplier for each product. s_tready is high
// only in idle. The output register holds a result until taken, and the next word
// is accepted meanwhile. Reset is synchronous and clears gains to their defaults
// and all loop state to zero.
module cascade_sliding_mode_thrust_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] yaw_angle, [63:32] surge_speed, [95:64] sway_speed, [127:96] yaw_rate,
  // [159:128] surge_target, [191:160] sway_target
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [16:0] thrust_front_left, [33:17] thrust_front_right, [50:34] thrust_rear_left,
  // [67:51] thrust_rear_right, [71:68] zero
  output logic [71:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  typedef enum logic [36:0] {
    ST_IDLE  = 37'b1 << 0,  ST_H0   = 37'b1 << 1,  ST_H1   = 37'b1 << 2,
    ST_H2    = 37'b1 << 3,  ST_H3   = 37'b1 << 4,  ST_H4   = 37'b1 << 5,
    ST_H5    = 37'b1 << 6,  ST_H6   = 37'b1 << 7,  ST_SLA  = 37'b1 << 8,
    ST_SLB   = 37'b1 << 9,  ST_SLC  = 37'b1 << 10, ST_SLD  = 37'b1 << 11,
    ST_SLE   = 37'b1 << 12, ST_TW0  = 37'b1 << 13, ST_TWW  = 37'b1 << 14,
    ST_TW1   = 37'b1 << 15, ST_TW2  = 37'b1 << 16, ST_TW3  = 37'b1 << 17,
    ST_SP0   = 37'b1 << 18, ST_SP1  = 37'b1 << 19, ST_SP2  = 37'b1 << 20,
    ST_SPW   = 37'b1 << 21, ST_SP3  = 37'b1 << 22, ST_SP4  = 37'b1 << 23,
    ST_SP5   = 37'b1 << 24, ST_SP6  = 37'b1 << 25, ST_SP7  = 37'b1 << 26,
    ST_SP8   = 37'b1 << 27, ST_SP9  = 37'b1 << 28, ST_SP10 = 37'b1 << 29,
    ST_AMIN  = 37'b1 << 30, ST_AMSUB = 37'b1 << 31, ST_AMAX = 37'b1 << 32,
    ST_ADIV  = 37'b1 << 33, ST_ADW  = 37'b1 << 34, ST_APEND = 37'b1 << 35,
    ST_FIN   = 37'b1 << 36
  } state_t;

  state_t state;

  logic [30:0] gain [csmtc_pkg::NUM_CFG];

  logic signed [31:0] yaw, u, v, r, ut, vt;
  logic signed [31:0] hprev, hsum, epsi, epsid, pterm, rate_ref;
  logic signed [33:0] acc;
  logic signed [31:0] eprev [3];
  logic signed [31:0] esum [3];
  logic signed [31:0] sval [3];
  logic signed [31:0] twv [3];
  logic signed [31:0] ereg, speed, c1, tr, fu, fv, fr;
  logic signed [47:0] tt;
  logic [63:0]        uu;
  logic [1:0]         k;
  logic [1:0]         ix;
  logic               pass;
  csmtc_pkg::alloc_t  f [4];
  csmtc_pkg::alloc_t  mn, mx;

  csmtc_pkg::mul_req_t  mreq;
  csmtc_pkg::prod_t     mp;
  csmtc_pkg::sqrt_req_t sreq;
  csmtc_pkg::div_req_t  dreq;
  logic                 sq_done, dv_done;
  logic [31:0]          sq_root;
  logic [16:0]          dv_quo;

  // combinational helpers
  logic signed [31:0] qp;
  logic signed [33:0] eneg, eabs, ewrap, aep;
  logic signed [32:0] habs, isig;
  logic signed [31:0] errk, sum_new, rr_sat, frn;
  logic [30:0]        kroot, klin;
  logic signed [32:0] lam;
  csmtc_pkg::alloc_t  mn_c, mx_c, h03, h12;
  logic [31:0]        sabs;

  csmtc_mul u_mul (.clk(clk), .req(mreq), .p(mp));
  csmtc_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sreq), .done(sq_done), .root(sq_root));
  csmtc_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(dv_done), .quo(dv_quo));

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    qp    = csmtc_pkg::qm(mp);
    eneg  = -34'(yaw);
    eabs  = eneg[33] ? -eneg : eneg;
    ewrap = eneg;
    if (eabs >= 34'(csmtc_pkg::Q_PI)) begin
      ewrap = (eneg > 34'sd0) ? eneg - 34'(csmtc_pkg::Q_TWO_PI)
                              : eneg + 34'(csmtc_pkg::Q_TWO_PI);
    end
    aep  = epsi[31] ? -34'(epsi) : 34'(epsi);
    habs = hsum[31] ? -33'(hsum) : 33'(hsum);
    isig = epsi[31] ? -habs : habs;
    rr_sat = csmtc_pkg::sat32(66'(acc) + 66'(qp));
    frn    = qp;
    sabs   = sval[k][31] ? 32'(-33'(sval[k])) : 32'(sval[k]);
    case (k)
      2'd0: begin
        errk  = csmtc_pkg::sat32(66'(ut) - 66'(u));
        kroot = gain[csmtc_pkg::CFG_SURGE_ROOT];
        klin  = gain[csmtc_pkg::CFG_SURGE_LINEAR];
        lam   = 33'(csmtc_pkg::LAMBDA_SURGE);
      end
      2'd1: begin
        errk  = csmtc_pkg::sat32(66'(vt) - 66'(v));
        kroot = gain[csmtc_pkg::CFG_SWAY_ROOT];
        klin  = gain[csmtc_pkg::CFG_SWAY_LINEAR];
        lam   = 33'(csmtc_pkg::LAMBDA_SWAY);
      end
      default: begin
        errk  = csmtc_pkg::sat32(66'(rate_ref) - 66'(r));
        kroot = gain[csmtc_pkg::CFG_TURN_ROOT];
        klin  = gain[csmtc_pkg::CFG_TURN_LINEAR];
        lam   = 33'(csmtc_pkg::LAMBDA_TURN);
      end
    endcase
    sum_new = csmtc_pkg::sat32(66'(esum[k]) + csmtc_pkg::rnd17(mp));
    mn_c = f[0];
    mx_c = f[0];
    for (int i = 1; i < 4; i++) begin
      if (f[i] < mn_c) mn_c = f[i];
      if (f[i] > mx_c) mx_c = f[i];
    end
    h03 = (f[0] - f[3] + 40'sd1) >>> 1;
    h12 = (f[1] - f[2] + 40'sd1) >>> 1;
  end

  // operand selection for the shared units
  always_comb begin
    mreq          = '0;
    sreq.start    = 1'b0;
    sreq.radicand = {16'b0, sabs, 16'b0};
    dreq.start    = 1'b0;
    dreq.num      = 56'($unsigned(f[ix])) * 56'(csmtc_pkg::MAX_THRUST)
                    + 56'($unsigned(mx >>> 1));
    dreq.den      = $unsigned(mx);
    unique case (state)
      ST_H1: begin
        mreq.a = 33'(epsi) + 33'(hprev);
        mreq.b = 33'(csmtc_pkg::Q_STEP);
      end
      ST_H2: begin
        mreq.a = $signed({2'b00, gain[csmtc_pkg::CFG_HEADING_PROP]});
        mreq.b = 33'(epsi);
      end
      ST_H3: begin
        mreq.a = 33'(qp);
        mreq.b = (aep <= 34'(csmtc_pkg::Q_TENTH)) ? 33'(csmtc_pkg::Q_TENTH)
                                                  : 33'(csmtc_pkg::Q_ONE_HALF_3);
      end
      ST_H4: begin
        mreq.a = 33'(csmtc_pkg::HEADING_INT_GAIN);
        mreq.b = isig;
      end
      ST_H5: begin
        mreq.a = $signed({2'b00, gain[csmtc_pkg::CFG_HEADING_DERIV]});
        mreq.b = 33'(epsid);
      end
      ST_SLB: begin
        mreq.a = 33'(ereg) + 33'(eprev[k]);
        mreq.b = 33'(csmtc_pkg::Q_STEP);
      end
      ST_SLD: begin
        mreq.a = lam;
        mreq.b = 33'(esum[k]);
      end
      ST_TW0: sreq.start = 1'b1;
      ST_TW1: begin
        mreq.a = $signed({2'b00, kroot});
        mreq.b = $signed({1'b0, sq_root});
      end
      ST_TW2: begin
        mreq.a = $signed({2'b00, klin});
        mreq.b = 33'(sval[k]);
      end
      ST_SP0: begin
        mreq.a = 33'(u);
        mreq.b = 33'(u);
      end
      ST_SP1: begin
        mreq.a = 33'(v);
        mreq.b = 33'(v);
      end
      ST_SP2: begin
        sreq.start    = 1'b1;
        sreq.radicand = uu + mp[63:0];
      end
      ST_SP3: begin
        mreq.a = 33'(u);
        mreq.b = 33'(v);
      end
      ST_SP4: begin
        mreq.a = 33'(csmtc_pkg::Q_AUX_UV);
        mreq.b = 33'(qp);
      end
      ST_SP5: begin
        mreq.a = 33'(speed);
        mreq.b = 33'(r);
      end
      ST_SP6: begin
        mreq.a = 33'(csmtc_pkg::Q_AUX_SR);
        mreq.b = 33'(qp);
      end
      ST_SP7: begin
        mreq.a = 33'(csmtc_pkg::Q_HALF_COS);
        mreq.b = 33'(twv[0]);
      end
      ST_SP8: begin
        mreq.a = 33'(csmtc_pkg::Q_HALF_COS);
        mreq.b = 33'(twv[1]);
      end
      ST_SP9: begin
        mreq.a = 33'(csmtc_pkg::Q_INV_4D);
        mreq.b = 33'(tr);
      end
      ST_ADIV: dreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      gain[csmtc_pkg::CFG_SURGE_ROOT]    <= 31'(csmtc_pkg::RST_ROOT_GAIN);
      gain[csmtc_pkg::CFG_SURGE_LINEAR]  <= 31'(csmtc_pkg::RST_LINEAR_GAIN);
      gain[csmtc_pkg::CFG_SWAY_ROOT]     <= 31'(csmtc_pkg::RST_ROOT_GAIN);
      gain[csmtc_pkg::CFG_SWAY_LINEAR]   <= 31'(csmtc_pkg::RST_LINEAR_GAIN);
      gain[csmtc_pkg::CFG_TURN_ROOT]     <= 31'(csmtc_pkg::RST_ROOT_GAIN);
      gain[csmtc_pkg::CFG_TURN_LINEAR]   <= 31'(csmtc_pkg::RST_LINEAR_GAIN);
      gain[csmtc_pkg::CFG_HEADING_PROP]  <= 31'(csmtc_pkg::RST_PROP_GAIN);
      gain[csmtc_pkg::CFG_HEADING_DERIV] <= 31'(csmtc_pkg::RST_DERIV_GAIN);
      hprev <= '0;
      hsum  <= '0;
      for (int i = 0; i < 3; i++) begin
        eprev[i] <= '0;
        esum[i]  <= '0;
      end
      k    <= '0;
      ix   <= '0;
      pass <= 1'b0;
    end else begin
      if (cfg_we) begin
        gain[cfg_index] <= cfg_data;
      end
      // drop the taken word unless a new one is loaded in this cycle
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            yaw   <= s_tdata[31:0];
            u     <= s_tdata[63:32];
            v     <= s_tdata[95:64];
            r     <= s_tdata[127:96];
            ut    <= s_tdata[159:128];
            vt    <= s_tdata[191:160];
            state <= ST_H0;
          end
        end
        ST_H0: begin
          epsi  <= csmtc_pkg::sat32(66'(ewrap));
          epsid <= csmtc_pkg::sat32(-66'(r));
          state <= ST_H1;
        end
        ST_H1: state <= ST_H2;
        ST_H2: begin
          // clear the heading integral inside the deadband
          if (aep <= 34'(csmtc_pkg::Q_DEADBAND)) begin
            hsum <= '0;
          end else begin
            hsum <= csmtc_pkg::sat32(66'(hsum) + csmtc_pkg::rnd17(mp));
          end
          hprev <= epsi;
          state <= ST_H3;
        end
        ST_H3: begin
          pterm <= qp;
          state <= ST_H4;
        end
        ST_H4: begin
          if (aep <= 34'(csmtc_pkg::Q_TENTH) || aep >= 34'(csmtc_pkg::Q_ONE_HALF_3)) begin
            pterm <= qp;
          end
          state <= ST_H5;
        end
        ST_H5: begin
          acc   <= 34'(pterm) + 34'(qp);
          state <= ST_H6;
        end
        ST_H6: begin
          if (rr_sat > 32'(csmtc_pkg::Q_RATE_LIMIT)) begin
            rate_ref <= 32'(csmtc_pkg::Q_RATE_LIMIT);
          end else if (rr_sat < -32'(csmtc_pkg::Q_RATE_LIMIT)) begin
            rate_ref <= -32'(csmtc_pkg::Q_RATE_LIMIT);
          end else begin
            rate_ref <= rr_sat;
          end
          k     <= '0;
          state <= ST_SLA;
        end
        ST_SLA: begin
          ereg  <= errk;
          state <= ST_SLB;
        end
        ST_SLB: state <= ST_SLC;
        ST_SLC: begin
          esum[k]  <= sum_new;
          eprev[k] <= ereg;
          state    <= ST_SLD;
        end
        ST_SLD: state <= ST_SLE;
        ST_SLE: begin
          sval[k] <= csmtc_pkg::sat32(66'(ereg) + 66'(qp));
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_TW0;
          end else begin
            k     <= k + 2'd1;
            state <= ST_SLA;
          end
        end
        ST_TW0: state <= ST_TWW;
        ST_TWW: begin
          if (sq_done) state <= ST_TW1;
        end
        ST_TW1: state <= ST_TW2;
        ST_TW2: begin
          tt    <= sval[k][31] ? -48'(csmtc_pkg::rnd16(mp)) : 48'(csmtc_pkg::rnd16(mp));
          state <= ST_TW3;
        end
        ST_TW3: begin
          twv[k] <= csmtc_pkg::sat32(66'(tt) + 66'(qp));
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_SP0;
          end else begin
            k     <= k + 2'd1;
            state <= ST_TW0;
          end
        end
        ST_SP0: state <= ST_SP1;
        ST_SP1: begin
          uu    <= mp[63:0];
          state <= ST_SP2;
        end
        ST_SP2: state <= ST_SPW;
        ST_SPW: begin
          if (sq_done) state <= ST_SP3;
        end
        ST_SP3: begin
          speed <= sq_root[31] ? 32'sh7fffffff : $signed(sq_root);
          state <= ST_SP4;
        end
        ST_SP4: state <= ST_SP5;
        ST_SP5: begin
          c1    <= qp;
          state <= ST_SP6;
        end
        ST_SP6: state <= ST_SP7;
        ST_SP7: begin
          tr    <= csmtc_pkg::sat32(66'(twv[2]) - 66'(c1) - 66'(qp));
          state <= ST_SP8;
        end
        ST_SP8: begin
          fu    <= qp;
          state <= ST_SP9;
        end
        ST_SP9: begin
          fv    <= qp;
          state <= ST_SP10;
        end
        ST_SP10: begin
          fr    <= frn;
          f[0]  <= 40'(fu) + 40'(fv) + 40'(frn);
          f[1]  <= 40'(fu) - 40'(fv) - 40'(frn);
          f[2]  <= -40'(fu) + 40'(fv) - 40'(frn);
          f[3]  <= -40'(fu) - 40'(fv) + 40'(frn);
          pass  <= 1'b0;
          state <= ST_AMIN;
        end
        ST_AMIN: begin
          mn    <= mn_c;
          state <= ST_AMSUB;
        end
        ST_AMSUB: begin
          // shift so that no thruster is negative
          if (mn < 40'sd0) begin
            for (int i = 0; i < 4; i++) f[i] <= f[i] - mn;
          end
          state <= ST_AMAX;
        end
        ST_AMAX: begin
          mx <= mx_c;
          ix <= '0;
          if (mx_c > 40'(csmtc_pkg::MAX_THRUST)) state <= ST_ADIV;
          else state <= ST_APEND;
        end
        ST_ADIV: state <= ST_ADW;
        ST_ADW: begin
          if (dv_done) begin
            f[ix] <= 40'(dv_quo);
            if (ix == 2'd3) begin
              state <= ST_APEND;
            end else begin
              ix    <= ix + 2'd1;
              state <= ST_ADIV;
            end
          end
        end
        ST_APEND: begin
          if (!pass) begin
            // project back and restore the yaw share
            f[0]  <= h03 + 40'(fr);
            f[1]  <= h12 - 40'(fr);
            f[2]  <= -h12 - 40'(fr);
            f[3]  <= -h03 + 40'(fr);
            pass  <= 1'b1;
            state <= ST_AMIN;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            for (int i = 0; i < 4; i++) begin
              if (f[i] > 40'(csmtc_pkg::MAX_THRUST)) begin
                m_tdata[i*17 +: 17] <= 17'(csmtc_pkg::MAX_THRUST);
              end else if (f[i] < 40'sd0) begin
                m_tdata[i*17 +: 17] <= '0;
              end else begin
                m_tdata[i*17 +: 17] <= f[i][16:0];
              end
            end
            m_tdata[71:68] <= '0;
            m_tvalid       <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/csmtc_checker.sv]
// Port-level checks for the cascade thrust controller, bound to the top level.
// Depends on csmtc_pkg.
module csmtc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in work");

  a_thrust_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:0] <= 17'(csmtc_pkg::MAX_THRUST)
              && m_tdata[33:17] <= 17'(csmtc_pkg::MAX_THRUST)
              && m_tdata[50:34] <= 17'(csmtc_pkg::MAX_THRUST)
              && m_tdata[67:51] <= 17'(csmtc_pkg::MAX_THRUST)
              && m_tdata[71:68] == 4'b0)
    else $error("thrust command out of range");

endmodule

bind cascade_sliding_mode_thrust_controller csmtc_checker u_csmtc_checker (.*);
